/* sv/mvd_pkg.sv */
// Shared constants, types and microcode table of the magnetic vehicle detector.
package mvd_pkg;

  localparam int FRAC_BITS_DEF    = 20;
  localparam int AXIS_DIVISOR_DEF = 970;

  localparam int AXIS_W  = 16;
  // reciprocal scale for the axis divide: exact for magnitudes up to 2^15 and divisors below 2^12
  localparam int RECIP_SHIFT = 27;
  localparam int NORM_W  = 32;
  localparam int VAL_W   = 43;
  localparam int MAG_W   = 42;
  localparam int CHUNK_W = 21;
  localparam int COEF_W  = 28;
  localparam int PROD_W  = MAG_W + COEF_W;
  localparam int OUT_W   = 40;
  localparam int THR_W   = 32;
  localparam int CNT_W   = 8;

  localparam int RAM_DEPTH = 32;
  localparam int ADDR_W    = 5;
  localparam int NUM_UOPS  = 34;
  localparam int PC_W      = 6;
  localparam int COEF_IDX_W = 4;

  typedef logic [ADDR_W-1:0] addr_t;

  // value store map
  localparam addr_t R_D0 = 5'd0;
  localparam addr_t R_D1 = 5'd1;
  localparam addr_t R_D2 = 5'd2;
  localparam addr_t R_D3 = 5'd3;
  localparam addr_t R_D4 = 5'd4;
  localparam addr_t R_D5 = 5'd5;
  localparam addr_t R_D6 = 5'd6;
  localparam addr_t R_D7 = 5'd7;
  localparam addr_t R_D8 = 5'd8;
  localparam addr_t R_IN = 5'd9;
  localparam addr_t R_O0 = 5'd10;
  localparam addr_t R_O1 = 5'd11;
  localparam addr_t R_O2 = 5'd12;
  localparam addr_t R_O3 = 5'd13;
  localparam addr_t R_O4 = 5'd14;
  localparam addr_t R_O5 = 5'd15;
  localparam addr_t R_O6 = 5'd16;
  localparam addr_t R_O7 = 5'd17;
  localparam addr_t R_O8 = 5'd18;
  localparam addr_t R_T  = 5'd19;
  localparam addr_t R_Y  = 5'd20;
  // never written, so it always reads as zero
  localparam addr_t R_ZERO = 5'd21;

  localparam logic [COEF_IDX_W-1:0] COEF_HALF = 4'd9;

  typedef enum logic [2:0] {
    OP_SUB  = 3'd0,
    OP_ADD  = 3'd1,
    OP_NSUB = 3'd2,
    OP_RSUB = 3'd3,
    OP_RADD = 3'd4,
    OP_MUL  = 3'd5
  } op_t;

  typedef struct packed {
    op_t                   op;
    addr_t                 dst;
    addr_t                 a;
    addr_t                 b;
    logic [COEF_IDX_W-1:0] coef;
  } uop_t;

  localparam logic [1:0] PRES_NONE  = 2'd0;
  localparam logic [1:0] PRES_MAYBE = 2'd1;
  localparam logic [1:0] PRES_CAR   = 2'd2;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_CONFIRM   = 2'd1;
  localparam logic [1:0] CFG_RELEASE   = 2'd2;

  function automatic uop_t mk(op_t op, addr_t dst, addr_t a, addr_t b,
                              logic [COEF_IDX_W-1:0] k);
    uop_t u;
    u.op = op; u.dst = dst; u.a = a; u.b = b; u.coef = k;
    return u;
  endfunction

  // lattice filter program, one adaptor after another
  function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_SUB,  R_O0, R_D0, R_IN, 4'd0);
      6'd1:  u = mk(OP_MUL,  R_T,  R_O0, R_ZERO, 4'd0);
      6'd2:  u = mk(OP_SUB,  R_D0, R_D0, R_T, 4'd0);
      6'd3:  u = mk(OP_SUB,  R_O4, R_D4, R_D3, 4'd0);
      6'd4:  u = mk(OP_MUL,  R_T,  R_O4, R_ZERO, 4'd4);
      6'd5:  u = mk(OP_SUB,  R_D4, R_D4, R_T, 4'd0);
      6'd6:  u = mk(OP_RSUB, R_T,  R_O0, R_O4, 4'd0);
      6'd7:  u = mk(OP_MUL,  R_T,  R_T, R_ZERO, 4'd3);
      6'd8:  u = mk(OP_SUB,  R_O3, R_T, R_O4, 4'd0);
      6'd9:  u = mk(OP_RADD, R_T,  R_O3, R_O4, 4'd0);
      6'd10: u = mk(OP_SUB,  R_D3, R_T, R_O0, 4'd0);
      6'd11: u = mk(OP_SUB,  R_O8, R_D8, R_D7, 4'd0);
      6'd12: u = mk(OP_MUL,  R_T,  R_O8, R_ZERO, 4'd8);
      6'd13: u = mk(OP_SUB,  R_D8, R_D8, R_T, 4'd0);
      6'd14: u = mk(OP_SUB,  R_O7, R_O3, R_O8, 4'd0);
      6'd15: u = mk(OP_MUL,  R_T,  R_O7, R_ZERO, 4'd7);
      6'd16: u = mk(OP_NSUB, R_D7, R_O8, R_T, 4'd0);
      6'd17: u = mk(OP_SUB,  R_O2, R_D2, R_D1, 4'd0);
      6'd18: u = mk(OP_MUL,  R_T,  R_O2, R_ZERO, 4'd2);
      6'd19: u = mk(OP_SUB,  R_D2, R_D2, R_T, 4'd0);
      6'd20: u = mk(OP_RSUB, R_T,  R_IN, R_O2, 4'd0);
      6'd21: u = mk(OP_MUL,  R_T,  R_T, R_ZERO, 4'd1);
      6'd22: u = mk(OP_SUB,  R_O1, R_T, R_O2, 4'd0);
      6'd23: u = mk(OP_RADD, R_T,  R_O1, R_O2, 4'd0);
      6'd24: u = mk(OP_SUB,  R_D1, R_T, R_IN, 4'd0);
      6'd25: u = mk(OP_SUB,  R_O6, R_D6, R_D5, 4'd0);
      6'd26: u = mk(OP_MUL,  R_T,  R_O6, R_ZERO, 4'd6);
      6'd27: u = mk(OP_ADD,  R_D6, R_D6, R_T, 4'd0);
      6'd28: u = mk(OP_SUB,  R_O5, R_O1, R_O6, 4'd0);
      6'd29: u = mk(OP_MUL,  R_T,  R_O5, R_ZERO, 4'd5);
      6'd30: u = mk(OP_NSUB, R_D5, R_O6, R_T, 4'd0);
      6'd31: u = mk(OP_RADD, R_T,  R_O7, R_O5, 4'd0);
      6'd32: u = mk(OP_MUL,  R_T,  R_T, R_ZERO, COEF_HALF);
      6'd33: u = mk(OP_SUB,  R_Y,  R_T, R_ZERO, 4'd0);
      default: u = mk(OP_SUB, R_T, R_ZERO, R_ZERO, 4'd0);
    endcase
    return u;
  endfunction

  // coefficient k as fixed point, rounded from ten decimal places
  function automatic logic [COEF_W-1:0] coef_val(int frac, int k);
    longint unsigned dec;
    longint unsigned r;
    case (k)
      0:       dec = 64'd4234661460;
      1:       dec = 64'd3597645462;
      3:       dec = 64'd4452593625;
      5:       dec = 64'd4006784558;
      7:       dec = 64'd1600876451;
      default: dec = 64'd1345877647;
    endcase
    r = ((dec << frac) + 64'd5000000000) / 64'd10000000000;
    if (k == int'(COEF_HALF)) r = 64'd1 << (frac - 1);
    return r[COEF_W-1:0];
  endfunction

  function automatic logic [THR_W-1:0] thr_reset(int frac);
    longint unsigned r;
    r = ((64'd1096 << frac) + 64'd5000) / 64'd10000;
    return r[THR_W-1:0];
  endfunction

  // clamp to the signed 40-bit range, kept at store width
  function automatic logic [VAL_W-1:0] sat40(logic signed [VAL_W:0] v);
    logic signed [VAL_W:0] hi;
    logic signed [VAL_W:0] lo;
    hi = (VAL_W+1)'((64'd1 << (OUT_W - 1)) - 64'd1);
    lo = -hi - (VAL_W+1)'(1);
    if (v > hi) return hi[VAL_W-1:0];
    if (v < lo) return lo[VAL_W-1:0];
    return v[VAL_W-1:0];
  endfunction

endpackage

/* sv/mvd_ram.sv */
// Generic RAM: one write port, two registered read ports.
module mvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/mvd_mulu.sv */
// Two-pass unsigned multiplier: one narrow multiplier used on each half of the wide operand.
module mvd_mulu import mvd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  a,
  input  logic [COEF_W-1:0] b,
  output logic              done,
  output logic [PROD_W-1:0] p
);

  logic [MAG_W-1:0]          a_r;
  logic [COEF_W-1:0]         b_r;
  logic                      ph_lo;
  logic                      ph_hi;
  logic [CHUNK_W-1:0]        chunk;
  logic [CHUNK_W+COEF_W-1:0] pp;

  assign chunk = ph_lo ? a_r[CHUNK_W-1:0] : a_r[MAG_W-1:CHUNK_W];
  assign pp    = chunk * b_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_lo <= 1'b0;
      ph_hi <= 1'b0;
      done  <= 1'b0;
    end else begin
      done  <= ph_hi;
      ph_hi <= ph_lo;
      ph_lo <= start;
    end
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph_lo) begin
      p <= PROD_W'(pp);
    end else if (ph_hi) begin
      p <= p + (PROD_W'(pp) << CHUNK_W);
    end
  end

endmodule

/* sv/magnetic_vehicle_detector.sv */
// Magnetic vehicle detector: axis divide, norm, lattice lowpass, presence state machine.
// Per sample: three reciprocal divides and squares on one shared two-pass multiplier, then
// the 34-step filter program, then the result is loaded. One sample at a time: in_ready
// is high only in idle, and a stalled result holds the finish step.
// Synchronous reset clears filter state, presence state and loads default registers.
module magnetic_vehicle_detector import mvd_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int AXIS_DIVISOR = AXIS_DIVISOR_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [AXIS_W-1:0] field_x,
  input  logic signed [AXIS_W-1:0] field_y,
  input  logic signed [AXIS_W-1:0] field_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  filtered_norm,
  output logic [1:0]               presence_state,
  output logic                     event_valid,
  output logic                     event_car,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [THR_W-1:0]         cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_SQ    = 8'b0000_0100,
    S_FETCH = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_RND   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  localparam logic [COEF_W-1:0] RECIP = COEF_W'(
    ((64'd1 << RECIP_SHIFT) + 64'(AXIS_DIVISOR) - 64'd1) / 64'(AXIS_DIVISOR));
  localparam logic [COEF_W-1:0] COEF_TAB [10] = '{
    coef_val(FRAC_BITS, 0), coef_val(FRAC_BITS, 1), coef_val(FRAC_BITS, 2),
    coef_val(FRAC_BITS, 3), coef_val(FRAC_BITS, 4), coef_val(FRAC_BITS, 5),
    coef_val(FRAC_BITS, 6), coef_val(FRAC_BITS, 7), coef_val(FRAC_BITS, 8),
    coef_val(FRAC_BITS, 9)
  };
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [VAL_W-1:0] IN_MAX = VAL_W'((64'd1 << (OUT_W - 1)) - 64'd1);

  state_t state;

  logic [THR_W-1:0] detect_threshold;
  logic [CNT_W-1:0] confirm_max;
  logic [CNT_W-1:0] release_min;

  logic [AXIS_W-1:0] ax_y;
  logic [AXIS_W-1:0] ax_z;
  logic [1:0]        axis;
  logic [NORM_W-1:0] norm;

  logic [AXIS_W-1:0] ax_raw;
  logic [AXIS_W-1:0] mag_sel;
  logic [AXIS_W-1:0] quot_now;
  logic [NORM_W-1:0] norm_next;
  logic [VAL_W-1:0]  filt_in;

  logic [PC_W-1:0]  pc;
  uop_t             u;
  logic [RAM_DEPTH-1:0] vld;
  logic             ok_a;
  logic             ok_b;
  logic [VAL_W-1:0] ram_a;
  logic [VAL_W-1:0] ram_b;
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;
  logic signed [VAL_W:0]   alu_sum;
  logic [VAL_W-1:0] alu_res;

  logic              we;
  addr_t             waddr;
  logic [VAL_W-1:0]  wdata;

  logic              mul_start;
  logic [MAG_W-1:0]  mul_a;
  logic [COEF_W-1:0] mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_p;
  logic              mul_neg;
  logic [PROD_W-1:0] rnd_sum;
  logic [MAG_W-1:0]  rnd_mag;
  logic [VAL_W-1:0]  rnd_val;

  logic [VAL_W-1:0]  y_val;
  logic              ge;
  logic [1:0]        pres;
  logic [CNT_W-1:0]  cnt;
  logic              seen;
  logic [1:0]        pres_next;
  logic [CNT_W-1:0]  cnt_next;
  logic              seen_next;
  logic              ev_next;
  logic              evc_next;
  logic              out_free;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign u         = uop_rom(pc);

  // magnitude of the axis to divide next; divide by reciprocal multiply, truncating
  assign ax_raw    = (state == S_IDLE) ? field_x : ((axis == 2'd0) ? ax_y : ax_z);
  assign mag_sel   = ax_raw[AXIS_W-1] ? AXIS_W'(-ax_raw) : ax_raw;
  assign quot_now  = AXIS_W'(mul_p >> RECIP_SHIFT);
  assign norm_next = norm + mul_p[NORM_W-1:0];
  assign filt_in   = ((norm_next >> (OUT_W - 1 - FRAC_BITS)) != '0) ? IN_MAX
                   : VAL_W'({norm_next, FRAC_BITS'(0)});

  assign rd_a = ok_a ? ram_a : '0;
  assign rd_b = ok_b ? ram_b : '0;

  always_comb begin
    case (u.op)
      OP_SUB, OP_RSUB: alu_sum = {rd_a[VAL_W-1], rd_a} - {rd_b[VAL_W-1], rd_b};
      OP_ADD, OP_RADD: alu_sum = {rd_a[VAL_W-1], rd_a} + {rd_b[VAL_W-1], rd_b};
      OP_NSUB:         alu_sum = -{rd_a[VAL_W-1], rd_a} - {rd_b[VAL_W-1], rd_b};
      default:         alu_sum = '0;
    endcase
    if (u.op == OP_RSUB || u.op == OP_RADD) begin
      alu_res = alu_sum[VAL_W-1:0];
    end else begin
      alu_res = sat40(alu_sum);
    end
  end

  assign rnd_sum = mul_p + ROUND_HALF;
  assign rnd_val = mul_neg ? VAL_W'(-{1'b0, rnd_mag}) : VAL_W'({1'b0, rnd_mag});

  always_comb begin
    we        = 1'b0;
    waddr     = u.dst;
    wdata     = alu_res;
    mul_start = 1'b0;
    mul_a     = rd_a[VAL_W-1] ? MAG_W'(-rd_a) : MAG_W'(rd_a);
    mul_b     = COEF_TAB[u.coef];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          mul_start = 1'b1;
          mul_a     = MAG_W'(mag_sel);
          mul_b     = RECIP;
        end
      end
      S_DIV: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MAG_W'(quot_now);
          mul_b     = COEF_W'(quot_now);
        end
      end
      S_SQ: begin
        waddr = R_IN;
        wdata = filt_in;
        we    = mul_done && (axis == 2'd2);
        if (mul_done && axis != 2'd2) begin
          mul_start = 1'b1;
          mul_a     = MAG_W'(mag_sel);
          mul_b     = RECIP;
        end
      end
      S_EXEC: begin
        mul_start = (u.op == OP_MUL);
        we        = (u.op != OP_MUL);
      end
      S_RND: begin
        we    = 1'b1;
        wdata = rnd_val;
      end
      default: ;
    endcase
  end

  mvd_ram #(.WIDTH(VAL_W), .DEPTH(RAM_DEPTH)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (u.a),
    .raddr_b (u.b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  mvd_mulu u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // presence decision for the finished sample
  assign ge = $signed({y_val[VAL_W-1], y_val}) >= $signed({{(VAL_W-THR_W+1){1'b0}},
                                                           detect_threshold});

  always_comb begin
    pres_next = pres;
    cnt_next  = cnt;
    seen_next = seen;
    ev_next   = 1'b0;
    evc_next  = 1'b0;
    case (pres)
      PRES_NONE: begin
        if (ge) begin
          cnt_next  = CNT_W'(1);
          pres_next = PRES_MAYBE;
        end
      end
      PRES_MAYBE: begin
        if (ge && cnt < confirm_max) begin
          cnt_next = cnt + CNT_W'(1);
        end else if (!ge && cnt > release_min) begin
          cnt_next = cnt - CNT_W'(1);
        end else if (!ge) begin
          pres_next = PRES_NONE;
          cnt_next  = '0;
          if (seen) begin
            seen_next = 1'b0;
            ev_next   = 1'b1;
          end
        end else begin
          pres_next = PRES_CAR;
          if (!seen) begin
            seen_next = 1'b1;
            ev_next   = 1'b1;
            evc_next  = 1'b1;
          end
        end
      end
      PRES_CAR: begin
        if (!ge) begin
          cnt_next  = cnt - CNT_W'(1);
          pres_next = PRES_MAYBE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_threshold <= thr_reset(FRAC_BITS);
      confirm_max      <= CNT_W'(10);
      release_min      <= CNT_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: detect_threshold <= cfg_data;
        CFG_CONFIRM:   confirm_max      <= cfg_data[CNT_W-1:0];
        CFG_RELEASE:   release_min      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ok_a <= vld[u.a];
    ok_b <= vld[u.b];
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pres      <= PRES_NONE;
      cnt       <= '0;
      seen      <= 1'b0;
      pc        <= '0;
      axis      <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ax_y  <= field_y;
            ax_z  <= field_z;
            axis  <= '0;
            norm  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (mul_done) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            norm <= norm_next;
            axis <= axis + 2'd1;
            if (axis == 2'd2) begin
              pc    <= '0;
              state <= S_FETCH;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_FETCH: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (u.op == OP_MUL) begin
            mul_neg <= rd_a[VAL_W-1];
            state   <= S_MUL;
          end else if (pc == PC_W'(NUM_UOPS - 1)) begin
            y_val <= alu_res;
            state <= S_FIN;
          end else begin
            pc    <= pc + PC_W'(1);
            state <= S_FETCH;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            rnd_mag <= MAG_W'(rnd_sum >> FRAC_BITS);
            state   <= S_RND;
          end
        end
        S_RND: begin
          pc    <= pc + PC_W'(1);
          state <= S_FETCH;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid      <= 1'b1;
            filtered_norm  <= y_val[OUT_W-1:0];
            presence_state <= pres_next;
            event_valid    <= ev_next;
            event_car      <= evc_next;
            pres           <= pres_next;
            cnt            <= cnt_next;
            seen           <= seen_next;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_valid |->
      (event_car && presence_state == PRES_CAR) ||
      (!event_car && presence_state == PRES_NONE))
    else $error("event report disagrees with presence state");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result loaded outside the finish step");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> pc < PC_W'(NUM_UOPS))
    else $error("filter program counter out of range");

  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_DIV || state == S_SQ || state == S_MUL))
    else $error("multiplier finished with nobody waiting");

endmodule
